FILE: rtl/cvs_pkg.sv
package cvs_pkg;

   // Default widths of the level inputs and the product totals.
   localparam int LEVEL_WIDTH_DEFAULT = 16;
   localparam int TOTAL_WIDTH_DEFAULT = 16;

   // Width of the fixed configuration fields.
   localparam int THRESHOLD_WIDTH = 16;
   localparam int WINDOW_WIDTH    = 4;
   localparam int TALLY_WIDTH     = 4;

   // Configuration port geometry: two word registers at byte addresses 0 and 4.
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DARK_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_LENGTH  = 1'b1;

   localparam logic [THRESHOLD_WIDTH-1:0] DARK_THRESHOLD_RESET = 16'd100;
   localparam logic [WINDOW_WIDTH-1:0]    WINDOW_LENGTH_RESET  = 4'd5;

   // Class of one reading, also used as the sort target code.
   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_RED   = 2'd1,
      CLASS_BLUE  = 2'd2,
      CLASS_GREEN = 2'd3
   } class_type;

endpackage

FILE: rtl/cvs_classify.sv
module cvs_classify #(
   parameter int LEVEL_WIDTH = cvs_pkg::LEVEL_WIDTH_DEFAULT
) (
   input  logic [LEVEL_WIDTH-1:0]                red_level,
   input  logic [LEVEL_WIDTH-1:0]                green_level,
   input  logic [LEVEL_WIDTH-1:0]                blue_level,
   input  logic [cvs_pkg::THRESHOLD_WIDTH-1:0]   dark_threshold,
   output cvs_pkg::class_type                    reading_class
);

   // Compare in a width that holds both a level and the threshold.
   localparam int CMP_WIDTH = (LEVEL_WIDTH > cvs_pkg::THRESHOLD_WIDTH) ?
                              LEVEL_WIDTH : cvs_pkg::THRESHOLD_WIDTH;

   logic [CMP_WIDTH-1:0] red_ext;
   logic [CMP_WIDTH-1:0] green_ext;
   logic [CMP_WIDTH-1:0] blue_ext;
   logic [CMP_WIDTH-1:0] thr_ext;
   logic                 red_dark;
   logic                 green_dark;
   logic                 blue_dark;
   logic                 mostly_dark;

   assign red_ext   = CMP_WIDTH'(red_level);
   assign green_ext = CMP_WIDTH'(green_level);
   assign blue_ext  = CMP_WIDTH'(blue_level);
   assign thr_ext   = CMP_WIDTH'(dark_threshold);

   assign red_dark    = red_ext < thr_ext;
   assign green_dark  = green_ext < thr_ext;
   assign blue_dark   = blue_ext < thr_ext;
   assign mostly_dark = (red_dark & green_dark) | (red_dark & blue_dark) |
                        (green_dark & blue_dark);

   // A tie for the largest level leaves the reading unidentified.
   always_comb begin
      if (mostly_dark) begin
         reading_class = cvs_pkg::CLASS_NONE;
      end else if (red_level > blue_level && red_level > green_level) begin
         reading_class = cvs_pkg::CLASS_RED;
      end else if (blue_level > red_level && blue_level > green_level) begin
         reading_class = cvs_pkg::CLASS_BLUE;
      end else if (green_level > red_level && green_level > blue_level) begin
         reading_class = cvs_pkg::CLASS_GREEN;
      end else begin
         reading_class = cvs_pkg::CLASS_NONE;
      end
   end

endmodule

FILE: rtl/color_vote_sorter.sv
// Color vote sorter.
// The request channel carries one beat per reading: an action bit and the red,
// green and blue pulse counts. Action 1 clears all tallies, product totals and
// the presence flag instead of classifying. Every request beat yields exactly
// one response beat with the class of the reading, a window-done flag, the
// color of a newly counted product, the presence flag and the product totals.
// The class, tally update and window vote are all done in the cycle a beat is
// accepted, and the response is registered. A new request beat can be taken
// every cycle, so throughput is one reading per cycle while the response side
// keeps up.
// Behind the response register sits a one-beat skid register. When the
// receiver stalls, the next beat still lands in the skid register; only when
// both hold a beat is the request side stalled, and it is released the cycle
// after the receiver takes the response.
// The CSR port holds dark_threshold at address 0 and window_length at 4, and
// should be written only while no beat is in flight.
// Synchronous reset restores the register defaults (threshold 100, window 5),
// clears tallies, totals and presence, and empties both response registers.
module color_vote_sorter #(
   parameter int LEVEL_WIDTH = cvs_pkg::LEVEL_WIDTH_DEFAULT,
   parameter int TOTAL_WIDTH = cvs_pkg::TOTAL_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [LEVEL_WIDTH-1:0]              req_red_level,
   input  logic [LEVEL_WIDTH-1:0]              req_green_level,
   input  logic [LEVEL_WIDTH-1:0]              req_blue_level,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_reading_class,
   output logic                                rsp_window_done,
   output logic [1:0]                          rsp_sort_target,
   output logic                                rsp_product_present,
   output logic [TOTAL_WIDTH-1:0]              rsp_red_total,
   output logic [TOTAL_WIDTH-1:0]              rsp_blue_total,
   output logic [TOTAL_WIDTH-1:0]              rsp_green_total,
   output logic [TOTAL_WIDTH-1:0]              rsp_grand_total,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cvs_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [cvs_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [cvs_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int TW = cvs_pkg::TALLY_WIDTH;
   localparam int WW = cvs_pkg::WINDOW_WIDTH;

   typedef struct packed {
      cvs_pkg::class_type     reading_class;
      logic                   window_done;
      cvs_pkg::class_type     sort_target;
      logic                   product_present;
      logic [TOTAL_WIDTH-1:0] red_total;
      logic [TOTAL_WIDTH-1:0] blue_total;
      logic [TOTAL_WIDTH-1:0] green_total;
      logic [TOTAL_WIDTH-1:0] grand_total;
   } result_type;

   // ---------------------------------------------------------------- CSRs
   logic [cvs_pkg::THRESHOLD_WIDTH-1:0] dark_threshold_ff;
   logic [WW-1:0]                       window_length_ff;
   logic                                csr_write;
   logic [cvs_pkg::CSR_INDEX_WIDTH-1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[cvs_pkg::CSR_ADDR_WIDTH-1 -: cvs_pkg::CSR_INDEX_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_threshold_ff <= cvs_pkg::DARK_THRESHOLD_RESET;
         window_length_ff  <= cvs_pkg::WINDOW_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            cvs_pkg::REG_DARK_THRESHOLD: begin
               dark_threshold_ff <= csr_pwdata[cvs_pkg::THRESHOLD_WIDTH-1:0];
            end
            cvs_pkg::REG_WINDOW_LENGTH: begin
               window_length_ff <= csr_pwdata[WW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cvs_pkg::REG_DARK_THRESHOLD: begin
            csr_prdata = cvs_pkg::CSR_DATA_WIDTH'(dark_threshold_ff);
         end
         cvs_pkg::REG_WINDOW_LENGTH: begin
            csr_prdata = cvs_pkg::CSR_DATA_WIDTH'(window_length_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ------------------------------------------------------ reading classes
   cvs_pkg::class_type level_class;
   cvs_pkg::class_type reading_class;

   cvs_classify #(
      .LEVEL_WIDTH (LEVEL_WIDTH)
   ) u_classify (
      .red_level      (req_red_level),
      .green_level    (req_green_level),
      .blue_level     (req_blue_level),
      .dark_threshold (dark_threshold_ff),
      .reading_class  (level_class)
   );

   // A clear beat reports an unidentified class.
   assign reading_class = req_action ? cvs_pkg::CLASS_NONE : level_class;

   // -------------------------------------------------- tallies and voting
   logic [TW-1:0]          red_tally_ff,   red_tally_in;
   logic [TW-1:0]          blue_tally_ff,  blue_tally_in;
   logic [TW-1:0]          green_tally_ff, green_tally_in;
   logic [TW-1:0]          dark_tally_ff,  dark_tally_in;
   logic [WW-1:0]          window_pos_ff,  window_pos_in;
   logic                   presence_ff,    presence_in;
   logic [TOTAL_WIDTH-1:0] red_prod_ff,    red_prod_in;
   logic [TOTAL_WIDTH-1:0] blue_prod_ff,   blue_prod_in;
   logic [TOTAL_WIDTH-1:0] green_prod_ff,  green_prod_in;

   logic [TW-1:0]          red_votes;
   logic [TW-1:0]          blue_votes;
   logic [TW-1:0]          green_votes;
   logic [TW-1:0]          dark_votes;
   logic                   window_close;
   logic                   red_wins;
   logic                   blue_wins;
   logic                   green_wins;
   logic                   dark_wins;
   cvs_pkg::class_type     sort_target;
   result_type             result;

   // Tallies including this reading; the vote looks at these.
   assign red_votes   = red_tally_ff   + TW'(reading_class == cvs_pkg::CLASS_RED);
   assign blue_votes  = blue_tally_ff  + TW'(reading_class == cvs_pkg::CLASS_BLUE);
   assign green_votes = green_tally_ff + TW'(reading_class == cvs_pkg::CLASS_GREEN);
   assign dark_votes  = dark_tally_ff  + TW'(reading_class == cvs_pkg::CLASS_NONE);

   // A zero window length closes every window, just as a length of one does.
   assign window_close = ({1'b0, window_pos_ff} + (WW+1)'(1)) >= {1'b0, window_length_ff};

   assign red_wins   = red_votes > blue_votes && red_votes > green_votes &&
                       red_votes > dark_votes;
   assign blue_wins  = blue_votes > red_votes && blue_votes > green_votes &&
                       blue_votes > dark_votes;
   assign green_wins = green_votes > red_votes && green_votes > blue_votes &&
                       green_votes > dark_votes;
   assign dark_wins  = dark_votes > red_votes && dark_votes > green_votes &&
                       dark_votes > blue_votes;

   always_comb begin
      red_tally_in   = red_votes;
      blue_tally_in  = blue_votes;
      green_tally_in = green_votes;
      dark_tally_in  = dark_votes;
      window_pos_in  = window_pos_ff + WW'(1);
      presence_in    = presence_ff;
      red_prod_in    = red_prod_ff;
      blue_prod_in   = blue_prod_ff;
      green_prod_in  = green_prod_ff;
      sort_target    = cvs_pkg::CLASS_NONE;

      if (req_action) begin
         red_tally_in   = '0;
         blue_tally_in  = '0;
         green_tally_in = '0;
         dark_tally_in  = '0;
         window_pos_in  = '0;
         presence_in    = 1'b0;
         red_prod_in    = '0;
         blue_prod_in   = '0;
         green_prod_in  = '0;
      end else if (window_close) begin
         red_tally_in   = '0;
         blue_tally_in  = '0;
         green_tally_in = '0;
         dark_tally_in  = '0;
         window_pos_in  = '0;
         if (!presence_ff) begin
            // With no product in view, a clear color majority counts one.
            if (red_wins) begin
               red_prod_in = red_prod_ff + TOTAL_WIDTH'(1);
               presence_in = 1'b1;
               sort_target = cvs_pkg::CLASS_RED;
            end else if (blue_wins) begin
               blue_prod_in = blue_prod_ff + TOTAL_WIDTH'(1);
               presence_in  = 1'b1;
               sort_target  = cvs_pkg::CLASS_BLUE;
            end else if (green_wins) begin
               green_prod_in = green_prod_ff + TOTAL_WIDTH'(1);
               presence_in   = 1'b1;
               sort_target   = cvs_pkg::CLASS_GREEN;
            end
         end else if (dark_wins) begin
            // The product has left once unidentified readings dominate.
            presence_in = 1'b0;
         end
      end
   end

   always_comb begin
      result.reading_class   = reading_class;
      result.window_done     = ~req_action & window_close;
      result.sort_target     = sort_target;
      result.product_present = presence_in;
      result.red_total       = red_prod_in;
      result.blue_total      = blue_prod_in;
      result.green_total     = green_prod_in;
      result.grand_total     = red_prod_in + blue_prod_in + green_prod_in;
   end

   // ------------------------------------------------------- response buffer
   logic       req_accept;
   logic       rsp_take;
   logic       out_valid_ff,  out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       out_load_new;
   logic       out_load_skid;
   logic       skid_load;
   result_type out_ff;
   result_type skid_ff;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~skid_valid_ff;
   assign rsp_take   = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_load_new  = 1'b0;
      out_load_skid = 1'b0;
      skid_load     = 1'b0;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_load_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_load_new = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_tally_ff   <= '0;
         blue_tally_ff  <= '0;
         green_tally_ff <= '0;
         dark_tally_ff  <= '0;
         window_pos_ff  <= '0;
         presence_ff    <= 1'b0;
         red_prod_ff    <= '0;
         blue_prod_ff   <= '0;
         green_prod_ff  <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            red_tally_ff   <= red_tally_in;
            blue_tally_ff  <= blue_tally_in;
            green_tally_ff <= green_tally_in;
            dark_tally_ff  <= dark_tally_in;
            window_pos_ff  <= window_pos_in;
            presence_ff    <= presence_in;
            red_prod_ff    <= red_prod_in;
            blue_prod_ff   <= blue_prod_in;
            green_prod_ff  <= green_prod_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load_new) begin
         out_ff <= result;
      end else if (out_load_skid) begin
         out_ff <= skid_ff;
      end
      if (skid_load) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_reading_class   = out_ff.reading_class;
   assign rsp_window_done     = out_ff.window_done;
   assign rsp_sort_target     = out_ff.sort_target;
   assign rsp_product_present = out_ff.product_present;
   assign rsp_red_total       = out_ff.red_total;
   assign rsp_blue_total      = out_ff.blue_total;
   assign rsp_green_total     = out_ff.green_total;
   assign rsp_grand_total     = out_ff.grand_total;

endmodule

FILE: sim/color_vote_sorter_tb.sv
`timescale 1ns / 1ps

module color_vote_sorter_tb;

   // Extra wait after the last response; it covers the registered output and
   // the skid register behind it.
   localparam int SETTLE_CYCLES  = 4;
   // Cycles in a row with no accepted beat and no CSR traffic before the
   // run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;

   // One response beat as the block should present it.
   typedef struct {
      cvs_pkg::class_type reading_class;
      logic               window_done;
      cvs_pkg::class_type sort_target;
      logic               product_present;
      logic [15:0]        red_total;
      logic [15:0]        blue_total;
      logic [15:0]        green_total;
      logic [15:0]        grand_total;
   } sort_outcome_type;

   logic        clock;
   logic        reset;

   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [15:0] req_red_level;
   logic [15:0] req_green_level;
   logic [15:0] req_blue_level;

   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_reading_class;
   logic        rsp_window_done;
   logic [1:0]  rsp_sort_target;
   logic        rsp_product_present;
   logic [15:0] rsp_red_total;
   logic [15:0] rsp_blue_total;
   logic [15:0] rsp_green_total;
   logic [15:0] rsp_grand_total;

   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [cvs_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [cvs_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [cvs_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   color_vote_sorter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_red_level       (req_red_level),
      .req_green_level     (req_green_level),
      .req_blue_level      (req_blue_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_reading_class   (rsp_reading_class),
      .rsp_window_done     (rsp_window_done),
      .rsp_sort_target     (rsp_sort_target),
      .rsp_product_present (rsp_product_present),
      .rsp_red_total       (rsp_red_total),
      .rsp_blue_total      (rsp_blue_total),
      .rsp_green_total     (rsp_green_total),
      .rsp_grand_total     (rsp_grand_total),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // Model copy of the configuration registers.
   logic [cvs_pkg::THRESHOLD_WIDTH-1:0] dark_limit;
   logic [cvs_pkg::WINDOW_WIDTH-1:0]    window_size;

   // Model copy of the voting state and the product counters.
   logic [cvs_pkg::TALLY_WIDTH-1:0]  votes_red;
   logic [cvs_pkg::TALLY_WIDTH-1:0]  votes_blue;
   logic [cvs_pkg::TALLY_WIDTH-1:0]  votes_green;
   logic [cvs_pkg::TALLY_WIDTH-1:0]  votes_dark;
   logic [cvs_pkg::WINDOW_WIDTH-1:0] window_fill;
   logic                             present_now;
   logic [15:0]                      count_red;
   logic [15:0]                      count_blue;
   logic [15:0]                      count_green;

   // Outcomes of accepted readings whose response beat has not come yet.
   sort_outcome_type pending_outcomes[$];

   // When clear, neither side idles or stalls.
   bit idle_on;

   int mismatch_count;
   int readings_sent;
   int clears_sent;
   int windows_closed;
   int products_seen;
   int responses_checked;
   int settings_used;
   int quiet_cycles;

   // Scene used by the random generator: the color the sensor is looking at
   // and how many more readings it stays there.
   cvs_pkg::class_type scene_color;
   int                 scene_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Sorter model
   // ---------------------------------------------------------------------

   function automatic cvs_pkg::class_type classify_reading(logic [15:0] r, logic [15:0] g,
                                                           logic [15:0] b);
      int dark_count;
      dark_count = int'(r < dark_limit) + int'(g < dark_limit) + int'(b < dark_limit);
      // Two dark channels mean there is nothing in front of the sensor.
      if (dark_count >= 2) return cvs_pkg::CLASS_NONE;
      if (r > g && r > b) return cvs_pkg::CLASS_RED;
      if (b > r && b > g) return cvs_pkg::CLASS_BLUE;
      if (g > r && g > b) return cvs_pkg::CLASS_GREEN;
      // A tie for the brightest channel cannot be trusted.
      return cvs_pkg::CLASS_NONE;
   endfunction

   function automatic sort_outcome_type next_sort_outcome(logic action, logic [15:0] r,
                                                          logic [15:0] g, logic [15:0] b);
      sort_outcome_type res;
      res.reading_class = cvs_pkg::CLASS_NONE;
      res.window_done   = 1'b0;
      res.sort_target   = cvs_pkg::CLASS_NONE;
      if (action) begin
         // A clear wipes the window and the counters but not the registers.
         clears_sent++;
         votes_red   = '0;
         votes_blue  = '0;
         votes_green = '0;
         votes_dark  = '0;
         window_fill = '0;
         present_now = 1'b0;
         count_red   = '0;
         count_blue  = '0;
         count_green = '0;
      end else begin
         readings_sent++;
         res.reading_class = classify_reading(r, g, b);
         case (res.reading_class)
            cvs_pkg::CLASS_RED:   votes_red   = votes_red + 1'b1;
            cvs_pkg::CLASS_BLUE:  votes_blue  = votes_blue + 1'b1;
            cvs_pkg::CLASS_GREEN: votes_green = votes_green + 1'b1;
            default:              votes_dark  = votes_dark + 1'b1;
         endcase
         // A window length of zero acts like one, and a length lowered below
         // the current fill closes the window on the next reading.
         if ({1'b0, window_fill} + 5'd1 >= {1'b0, window_size}) begin
            res.window_done = 1'b1;
            windows_closed++;
            if (!present_now) begin
               if (votes_red > votes_blue && votes_red > votes_green &&
                   votes_red > votes_dark) begin
                  count_red       = count_red + 1'b1;
                  present_now     = 1'b1;
                  res.sort_target = cvs_pkg::CLASS_RED;
               end else if (votes_blue > votes_red && votes_blue > votes_green &&
                            votes_blue > votes_dark) begin
                  count_blue      = count_blue + 1'b1;
                  present_now     = 1'b1;
                  res.sort_target = cvs_pkg::CLASS_BLUE;
               end else if (votes_green > votes_red && votes_green > votes_blue &&
                            votes_green > votes_dark) begin
                  count_green     = count_green + 1'b1;
                  present_now     = 1'b1;
                  res.sort_target = cvs_pkg::CLASS_GREEN;
               end
               if (res.sort_target != cvs_pkg::CLASS_NONE) products_seen++;
            end else if (votes_dark > votes_red && votes_dark > votes_green &&
                         votes_dark > votes_blue) begin
               // The product has left once the window is mostly dark.
               present_now = 1'b0;
            end
            votes_red   = '0;
            votes_blue  = '0;
            votes_green = '0;
            votes_dark  = '0;
            window_fill = '0;
         end else begin
            window_fill = window_fill + 1'b1;
         end
      end
      res.product_present = present_now;
      res.red_total       = count_red;
      res.blue_total      = count_blue;
      res.green_total     = count_green;
      res.grand_total     = count_red + count_blue + count_green;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want)
         flag_mismatch($sformatf("%s of response %0d: expected %0h, got %0h",
                                 name, responses_checked, want, got));
   endtask

   // Every response beat is checked against the oldest pending outcome. The
   // stall is driven on the falling edge, so both are stable here.
   always @(posedge clock) begin
      sort_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch($sformatf("response beat with no reading pending, class %0d",
                                    rsp_reading_class));
         end else begin
            want = pending_outcomes.pop_front();
            check_field("reading_class", 16'(want.reading_class), 16'(rsp_reading_class));
            check_field("window_done", 16'(want.window_done), 16'(rsp_window_done));
            check_field("sort_target", 16'(want.sort_target), 16'(rsp_sort_target));
            check_field("product_present", 16'(want.product_present),
                        16'(rsp_product_present));
            check_field("red_total", want.red_total, rsp_red_total);
            check_field("blue_total", want.blue_total, rsp_blue_total);
            check_field("green_total", want.green_total, rsp_green_total);
            check_field("grand_total", want.grand_total, rsp_grand_total);
         end
         responses_checked++;
      end
   end

   // The receiver stalls at random while idling is on.
   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 22);
   end

   // Watchdog: a long run of cycles with no beat moving on either channel and
   // no CSR access means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles, %0d readings pending",
                  quiet_cycles, pending_outcomes.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Sends one request beat and holds it until the block accepts it. The
   // valid is left high so that back-to-back beats need no gap. Each idle
   // cycle is drawn on its own, so about a fifth of the cycles are idle.
   task automatic send_reading(logic action, logic [15:0] r, logic [15:0] g,
                               logic [15:0] b);
      while (idle_on && $urandom_range(99) < 22) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_action      <= action;
      req_red_level   <= r;
      req_green_level <= g;
      req_blue_level  <= b;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(next_sort_outcome(action, r, g, b));
   endtask

   task automatic send_clear();
      send_reading(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Stops sending and waits until every pending reading has been answered.
   task automatic drain_pending();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [cvs_pkg::CSR_INDEX_WIDTH-1:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= cvs_pkg::CSR_ADDR_WIDTH'(4 * index);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == cvs_pkg::REG_DARK_THRESHOLD)
         dark_limit = value[cvs_pkg::THRESHOLD_WIDTH-1:0];
      else
         window_size = value[cvs_pkg::WINDOW_WIDTH-1:0];
   endtask

   // Reads a register back and compares it with the model's copy.
   task automatic csr_check(logic [cvs_pkg::CSR_INDEX_WIDTH-1:0] index);
      logic [31:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= cvs_pkg::CSR_ADDR_WIDTH'(4 * index);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (index == cvs_pkg::REG_DARK_THRESHOLD)
         check_field("dark_threshold readback", dark_limit, got[15:0]);
      else
         check_field("window_length readback", 16'(window_size), 16'(got[3:0]));
   endtask

   task automatic apply_settings(logic [15:0] threshold, logic [3:0] length);
      drain_pending();
      // Junk in the unused upper data bits must not reach the registers.
      csr_write(cvs_pkg::REG_DARK_THRESHOLD, {16'($urandom), threshold});
      csr_write(cvs_pkg::REG_WINDOW_LENGTH, {28'($urandom), length});
      csr_check(cvs_pkg::REG_DARK_THRESHOLD);
      csr_check(cvs_pkg::REG_WINDOW_LENGTH);
      settings_used++;
   endtask

   // Builds levels that the current threshold classifies as the given color, or as
   // unidentified when the threshold is 65535. Unidentified readings get two dark
   // channels, or an exact tie when the threshold is zero and no channel can be dark.
   function automatic void shape_levels(cvs_pkg::class_type color, output logic [15:0] r,
                                        output logic [15:0] g, output logic [15:0] b);
      logic [15:0] lv[3];
      int          lead;
      int          runner;
      int          slot;
      int          limit;
      limit = dark_limit;
      if (color == cvs_pkg::CLASS_NONE || limit == 65535) begin
         if (limit == 0) begin
            lv[0] = 16'($urandom);
            lv[1] = lv[0];
            lv[2] = lv[0];
         end else begin
            lv[0] = 16'($urandom_range(limit - 1, 0));
            lv[1] = 16'($urandom_range(limit - 1, 0));
            lv[2] = 16'($urandom);
         end
         slot = $urandom_range(2);
      end else begin
         runner = $urandom_range(65534, limit);
         lead   = $urandom_range(65535, runner + 1);
         // Channel order is red, green, blue.
         slot   = (color == cvs_pkg::CLASS_RED) ? 0 :
                  (color == cvs_pkg::CLASS_GREEN) ? 1 : 2;
         lv[0]  = 16'(lead);
         lv[1]  = 16'(runner);
         lv[2]  = 16'($urandom_range(lead - 1, 0));
         if ($urandom_range(1)) begin
            lv[1] = lv[2];
            lv[2] = 16'(runner);
         end
      end
      r = lv[(3 - slot) % 3];
      g = lv[(4 - slot) % 3];
      b = lv[(5 - slot) % 3];
   endfunction

   // Random reading: mostly a scene that holds one color (or darkness) for a
   // few windows, so that products come and go; the rest is noise, ties and
   // an occasional clear.
   task automatic send_random_reading();
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      int          roll;
      int          tie_level;
      if (scene_left <= 0) begin
         scene_color = cvs_pkg::class_type'($urandom_range(3));
         scene_left  = $urandom_range(3, 1) * ((window_size == 0) ? 1 : window_size);
      end
      scene_left--;
      roll = $urandom_range(99);
      if (roll < 3) begin
         send_clear();
      end else if (roll < 15) begin
         send_reading(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (roll < 20) begin
         tie_level = $urandom_range(65535, dark_limit);
         r = 16'(tie_level);
         g = 16'(tie_level);
         b = 16'($urandom_range(tie_level, 0));
         case ($urandom_range(2))
            0: send_reading(1'b0, r, g, b);
            1: send_reading(1'b0, b, r, g);
            default: send_reading(1'b0, r, b, g);
         endcase
      end else begin
         shape_levels(scene_color, r, g, b);
         send_reading(1'b0, r, g, b);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // The registers must come out of reset with their documented defaults.
   task automatic test_register_defaults();
      csr_check(cvs_pkg::REG_DARK_THRESHOLD);
      csr_check(cvs_pkg::REG_WINDOW_LENGTH);
   endtask

   // Hand-picked readings at the default threshold of 100 and window of 5.
   task automatic test_directed_readings();
      // First window: mostly unidentified readings, so no product.
      send_reading(1'b0, 16'h0000, 16'h0000, 16'h0000);   // all dark
      send_reading(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // three-way tie
      send_reading(1'b0, 16'hFFFF, 16'h0000, 16'h0000);   // bright red but two dark
      send_reading(1'b0, 16'hFFFF, 16'd100, 16'd99);      // red, at the threshold edge
      send_reading(1'b0, 16'd99, 16'd99, 16'hFFFF);       // two just below threshold
      // Second window: a red majority counts a red product.
      send_reading(1'b0, 16'd900, 16'd200, 16'd300);
      send_reading(1'b0, 16'd901, 16'd200, 16'd900);
      send_reading(1'b0, 16'hFFFF, 16'hFFFE, 16'h0000);
      send_reading(1'b0, 16'd200, 16'd300, 16'd900);      // blue
      send_reading(1'b0, 16'd200, 16'd900, 16'd300);      // green
      // Third window: green readings while present do not count again.
      send_reading(1'b0, 16'd150, 16'hFFFF, 16'd150);
      send_reading(1'b0, 16'd150, 16'hFFFF, 16'd150);
      send_reading(1'b0, 16'd150, 16'hFFFF, 16'd150);
      send_reading(1'b0, 16'd0, 16'd0, 16'd0);
      send_reading(1'b0, 16'd150, 16'hFFFF, 16'd150);
      // Fourth window: a dark majority means the product has gone.
      send_reading(1'b0, 16'd500, 16'd500, 16'd200);      // red and green tie
      send_reading(1'b0, 16'd200, 16'd500, 16'd500);      // green and blue tie
      send_reading(1'b0, 16'd500, 16'd200, 16'd500);      // red and blue tie
      send_reading(1'b0, 16'd800, 16'd100, 16'd700);      // red
      send_reading(1'b0, 16'd100, 16'd700, 16'd800);      // blue
      // A clear in the middle of a window restarts everything.
      send_reading(1'b0, 16'd100, 16'd800, 16'd700);
      send_reading(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_reading(1'b0, 16'd100, 16'd800, 16'd700);
      send_reading(1'b1, 16'h0000, 16'hFFFF, 16'h0000);
   endtask

   // Shrinking the window below its current fill closes it on the next
   // reading; a length of zero closes a window on every reading.
   task automatic test_window_shrink();
      apply_settings(16'd100, 4'd10);
      repeat (4) send_reading(1'b0, 16'd100, 16'd400, 16'd2000);
      apply_settings(16'd100, 4'd2);
      repeat (3) send_reading(1'b0, 16'd100, 16'd400, 16'd2000);
      apply_settings(16'd100, 4'd0);
      send_reading(1'b0, 16'd5, 16'd6, 16'd7);
      send_reading(1'b0, 16'd400, 16'd100, 16'd200);
      send_reading(1'b0, 16'd400, 16'd100, 16'd200);
   endtask

   // Random readings under several settings, the extremes among them.
   task automatic test_random_traffic();
      logic [15:0] thresholds[6];
      logic [3:0]  lengths[6];
      thresholds = '{16'd100, 16'd0, 16'hFFFF, 16'd1, 16'($urandom),
                     16'($urandom_range(2000))};
      lengths    = '{4'd5, 4'd1, 4'd15, 4'd0, 4'($urandom_range(15, 1)),
                     4'($urandom_range(15))};
      for (int phase = 0; phase < 6; phase++) begin
         apply_settings(thresholds[phase], lengths[phase]);
         scene_left = 0;
         // The third setting runs without any idling on either side.
         idle_on = (phase != 2);
         for (int n = 0; n < 110; n++) begin
            // Once, let everything drain in the middle of a setting.
            if (phase == 4 && n == 60) drain_pending();
            send_random_reading();
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = 1'b0;
      req_red_level   = '0;
      req_green_level = '0;
      req_blue_level  = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      idle_on         = 1'b1;
      dark_limit      = cvs_pkg::DARK_THRESHOLD_RESET;
      window_size     = cvs_pkg::WINDOW_LENGTH_RESET;
      votes_red       = '0;
      votes_blue      = '0;
      votes_green     = '0;
      votes_dark      = '0;
      window_fill     = '0;
      present_now     = 1'b0;
      count_red       = '0;
      count_blue      = '0;
      count_green     = '0;
      scene_color     = cvs_pkg::CLASS_NONE;
      scene_left      = 0;
      mismatch_count  = 0;
      settings_used   = 1;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_directed_readings();
      test_window_shrink();
      test_random_traffic();

      drain_pending();
      if (pending_outcomes.size() != 0)
         flag_mismatch($sformatf("%0d readings never answered", pending_outcomes.size()));

      $display("Covered %0d readings and %0d clears under %0d register settings.",
               readings_sent, clears_sent, settings_used);
      $display("%0d windows voted, %0d products counted, %0d responses checked, %0d mismatches.",
               windows_closed, products_seen, responses_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
